### src/assert_macros.svh
// Assertion macros for the address unit modules; the queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge while reset is released.
`define STAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds while reset is released.
`define STAU_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define STAU_ASSERT(lbl, clk, rstn, prop)
`define STAU_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### src/stau_pkg.sv
// Types and constants for the single transfer address unit.
`default_nettype none

package stau_pkg;

  // Bit positions in the instruction word.
  localparam int unsigned BitSign     = 31;
  localparam int unsigned BitWordForm = 26;
  localparam int unsigned BitImmReg   = 25;
  localparam int unsigned BitPre      = 24;
  localparam int unsigned BitUp       = 23;
  localparam int unsigned BitByteImmh = 22;
  localparam int unsigned BitWb       = 21;
  localparam int unsigned BitLoad     = 20;

  // Default number of entries in the queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [1:0] {
    SizeWord = 2'd0,
    SizeByte = 2'd1,
    SizeHalf = 2'd2
  } size_e;

  typedef enum logic [1:0] {
    ShiftLsl = 2'd0,
    ShiftLsr = 2'd1,
    ShiftAsr = 2'd2,
    ShiftRor = 2'd3
  } shift_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] base_value;
    logic [31:0] index_value;
    logic [31:0] store_value;
    logic        carry_flag;
  } in_item_t;

  typedef struct packed {
    logic [31:0] mem_address;
    logic        is_load;
    size_e       access_size;
    logic [31:0] store_data;
    logic [3:0]  data_register;
    logic        writeback_enable;
    logic [3:0]  base_register;
    logic [31:0] writeback_value;
  } out_item_t;

  // A decoded transfer waiting for its address add.
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] offset;
    logic        up;
    logic        pre;
    logic        wb_en;
    logic        load;
    size_e       size;
    logic [31:0] store_data;
    logic [3:0]  rd;
    logic [3:0]  rn;
  } entry_t;

endpackage

`default_nettype wire

### src/stau_front.sv
// Front stage: decodes the instruction, forms the offset and masks store data.
`default_nettype none

module stau_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  stau_pkg::in_item_t  in_item_i,
  output logic                q_valid_o,
  input  wire                 q_stall_i,
  output stau_pkg::entry_t    q_entry_o
);

  logic             valid_q, valid_d;
  stau_pkg::entry_t entry_q, entry_d;

  logic [31:0]      ins;
  logic [31:0]      rm;
  logic [4:0]       amt;
  stau_pkg::shift_e kind;
  logic [31:0]      fill;
  logic [63:0]      rot;
  logic [31:0]      shifted;

  assign ins  = in_item_i.instruction;
  assign rm   = in_item_i.index_value;
  assign amt  = ins[11:7];
  assign kind = stau_pkg::shift_e'(ins[6:5]);
  assign fill = {32{rm[stau_pkg::BitSign]}};
  assign rot  = {rm, rm} >> amt;

  // Barrel shifter for the register offset, with the zero-amount encodings.
  always_comb begin
    case (kind)
      stau_pkg::ShiftLsl: shifted = rm << amt;
      stau_pkg::ShiftLsr: shifted = (amt == 5'd0) ? 32'd0 : (rm >> amt);
      stau_pkg::ShiftAsr: shifted = (amt == 5'd0) ? fill : 32'($signed(rm) >>> amt);
      stau_pkg::ShiftRor: begin
        if (amt == 5'd0) begin
          shifted = {in_item_i.carry_flag, rm[31:1]};
        end else begin
          shifted = rot[31:0];
        end
      end
      default: shifted = rm;
    endcase
  end

  always_comb begin
    entry_d       = '0;
    entry_d.base  = in_item_i.base_value;
    entry_d.up    = ins[stau_pkg::BitUp];
    entry_d.pre   = ins[stau_pkg::BitPre];
    entry_d.wb_en = !ins[stau_pkg::BitPre] || ins[stau_pkg::BitWb];
    entry_d.load  = ins[stau_pkg::BitLoad];
    entry_d.rd    = ins[15:12];
    entry_d.rn    = ins[19:16];
    if (ins[stau_pkg::BitWordForm]) begin
      entry_d.offset = ins[stau_pkg::BitImmReg] ? shifted : {20'd0, ins[11:0]};
      entry_d.size   = ins[stau_pkg::BitByteImmh] ? stau_pkg::SizeByte : stau_pkg::SizeWord;
    end else begin
      entry_d.offset = ins[stau_pkg::BitByteImmh] ? {24'd0, ins[11:8], ins[3:0]} : rm;
      entry_d.size   = stau_pkg::SizeHalf;
    end
    if (entry_d.load) begin
      entry_d.store_data = 32'd0;
    end else begin
      case (entry_d.size)
        stau_pkg::SizeByte: entry_d.store_data = {24'd0, in_item_i.store_value[7:0]};
        stau_pkg::SizeHalf: entry_d.store_data = {16'd0, in_item_i.store_value[15:0]};
        default:            entry_d.store_data = in_item_i.store_value;
      endcase
    end
  end

  // The stage holds its item only while the queue pushes back.
  assign in_stall_o = valid_q && q_stall_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      entry_q <= entry_d;
    end
  end

  assign q_valid_o = valid_q;
  assign q_entry_o = entry_q;

endmodule

`default_nettype wire

### src/stau_queue.sv
// Small first-in first-out queue between the decode and address stages.
`include "assert_macros.svh"
`default_nettype none

module stau_queue #(
  parameter int unsigned Depth = stau_pkg::QueueDepthDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_valid_i,
  output logic              push_stall_o,
  input  stau_pkg::entry_t  push_entry_i,
  output logic              pop_valid_o,
  input  wire               pop_stall_i,
  output stau_pkg::entry_t  pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  stau_pkg::entry_t    store_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_stall_o = (count_q == CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_entry_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // The fill level never passes the depth.
  `STAU_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(Depth))
  // A push alone raises the fill level by one.
  `STAU_ASSERT(a_push_counts, clk_i, rst_ni,
               (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
  // The read and write pointers meet only when the queue is empty or full.
  `STAU_ASSERT(a_ptr_meet, clk_i, rst_ni,
               (rd_ptr_q == wr_ptr_q) |-> (count_q == '0 || push_stall_o))

endmodule

`default_nettype wire

### src/stau_back.sv
// Back stage: adds or subtracts the offset and registers the result item.
`default_nettype none

module stau_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_valid_i,
  output logic                q_stall_o,
  input  stau_pkg::entry_t    q_entry_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output stau_pkg::out_item_t out_item_o
);

  logic                out_valid_q, out_valid_d;
  stau_pkg::out_item_t out_item_q, out_item_d;
  logic [31:0]         new_base;

  // One adder serves both directions: subtraction adds the inverted offset plus one.
  assign new_base = q_entry_i.base
                  + (q_entry_i.up ? q_entry_i.offset : ~q_entry_i.offset)
                  + {31'd0, !q_entry_i.up};

  always_comb begin
    out_item_d.mem_address      = q_entry_i.pre ? new_base : q_entry_i.base;
    out_item_d.is_load          = q_entry_i.load;
    out_item_d.access_size      = q_entry_i.size;
    out_item_d.store_data       = q_entry_i.store_data;
    out_item_d.data_register    = q_entry_i.rd;
    out_item_d.writeback_enable = q_entry_i.wb_en;
    out_item_d.base_register    = q_entry_i.rn;
    out_item_d.writeback_value  = new_base;
  end

  assign q_stall_o   = out_valid_q && out_stall_i;
  assign out_valid_d = q_stall_o ? out_valid_q : q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && !q_stall_o) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

### src/single_transfer_address_unit_core.sv
// Single data transfer address unit: decode, offset shift, address add and writeback.
//
// This block takes one load/store instruction with its base, index and store
// register values and the carry flag, and returns one memory request item with
// the access address, size, store data, data register and the base writeback.
// It accepts one item every clock cycle while the input is not stalled and returns
// one item every cycle when the output is not stalled. An item accepted at the input
// is registered in the decode stage register, where the barrel shifter has formed the
// offset, then written into the queue, and then registered in the address stage
// output register, whose 32-bit adder sets the cycle time and which offers it at the
// output. The queue between the decode and address stages holds QueueDepth items,
// two by default, so that a stall at the output reaches the input only after the
// queue has filled.
// The block keeps no state between items, and reset only empties the pipeline.
`default_nettype none

module single_transfer_address_unit_core #(
  parameter int unsigned QueueDepth = stau_pkg::QueueDepthDefault
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  stau_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output stau_pkg::out_item_t  out_item_o
);

  // Decoded items travel from the decode stage into the queue.
  logic             push_valid;
  logic             push_stall;
  stau_pkg::entry_t push_entry;

  // Queued items travel on to the address stage.
  logic             pop_valid;
  logic             pop_stall;
  stau_pkg::entry_t pop_entry;

  stau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (push_valid),
    .q_stall_i  (push_stall),
    .q_entry_o  (push_entry)
  );

  stau_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_entry_o  (pop_entry)
  );

  stau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_stall_o   (pop_stall),
    .q_entry_i   (pop_entry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### tb/sv/single_transfer_address_unit_core_tb.sv
// Self-checking testbench for the single transfer address unit core.
`timescale 1ns / 1ps

module single_transfer_address_unit_core_tb;
  import stau_pkg::*;

  // A stall-free run never goes this long without an item moving on either side.
  localparam int unsigned IdleCycleLimit = 2000;
  // Clock edges to wait after the last expected request has come out.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrintedMismatches = 40;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Expected memory requests, oldest first.
  out_item_t pending_requests[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  // When clear, neither the instruction side nor the request side ever idles.
  bit gaps_on = 1'b1;

  single_transfer_address_unit_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #2 clk_i = ~clk_i;

  // Computes the memory request that one load/store instruction produces. The offset
  // is a 12-bit immediate, the index register through the barrel shifter, or for the
  // halfword form a split 8-bit immediate or the plain index register.
  function automatic out_item_t predict_request(in_item_t item);
    logic [31:0]        ins;
    logic [31:0]        index;
    logic signed [31:0] index_signed;
    logic [4:0]         amount;
    shift_e             kind;
    logic [31:0]        offset;
    logic [31:0]        new_base;
    size_e              size;
    out_item_t          req;
    ins          = item.instruction;
    index        = item.index_value;
    index_signed = item.index_value;
    amount       = ins[11:7];
    kind         = shift_e'(ins[6:5]);
    if (ins[BitWordForm]) begin
      if (ins[BitImmReg]) begin
        // A zero amount has a special meaning for every kind but LSL.
        case (kind)
          ShiftLsl: offset = index << amount;
          ShiftLsr: offset = (amount == 5'd0) ? 32'd0 : index >> amount;
          ShiftAsr: offset = (amount == 5'd0) ? {32{index[31]}} :
                             $unsigned(index_signed >>> amount);
          default: begin
            if (amount == 5'd0) begin
              // Rotate with extend: the carry enters at the top.
              offset = {item.carry_flag, index[31:1]};
            end else begin
              offset = (index >> amount) | (index << (6'd32 - {1'b0, amount}));
            end
          end
        endcase
      end else begin
        offset = {20'd0, ins[11:0]};
      end
      size = ins[BitByteImmh] ? SizeByte : SizeWord;
    end else begin
      offset = ins[BitByteImmh] ? {24'd0, ins[11:8], ins[3:0]} : index;
      size   = SizeHalf;
    end
    new_base = ins[BitUp] ? item.base_value + offset : item.base_value - offset;

    req.mem_address = ins[BitPre] ? new_base : item.base_value;
    req.is_load     = ins[BitLoad];
    req.access_size = size;
    if (ins[BitLoad]) begin
      req.store_data = 32'd0;
    end else if (size == SizeByte) begin
      req.store_data = {24'd0, item.store_value[7:0]};
    end else if (size == SizeHalf) begin
      req.store_data = {16'd0, item.store_value[15:0]};
    end else begin
      req.store_data = item.store_value;
    end
    req.data_register    = ins[15:12];
    req.writeback_enable = !ins[BitPre] || ins[BitWb];
    req.base_register    = ins[19:16];
    req.writeback_value  = new_base;
    return req;
  endfunction

  // Builds an instruction word; the condition field is always "always".
  function automatic logic [31:0] transfer_word(int word_form, int reg_form, int pre, int up,
                                                int byte_imm, int wb, int load,
                                                logic [3:0] rn, logic [3:0] rd,
                                                logic [11:0] low_bits);
    logic [31:0] word;
    word               = 32'hE000_0000;
    word[BitWordForm]  = word_form[0];
    word[BitImmReg]    = reg_form[0];
    word[BitPre]       = pre[0];
    word[BitUp]        = up[0];
    word[BitByteImmh]  = byte_imm[0];
    word[BitWb]        = wb[0];
    word[BitLoad]      = load[0];
    word[19:16]        = rn;
    word[15:12]        = rd;
    word[11:0]         = low_bits;
    return word;
  endfunction

  // Low twelve bits of a register-offset word: amount, shift kind, bit 4 and index number.
  function automatic logic [11:0] shift_field(logic [4:0] amount, shift_e kind, int bit4);
    return {amount, kind, bit4[0], 4'd3};
  endfunction

  function automatic in_item_t make_transfer(logic [31:0] ins, logic [31:0] base,
                                             logic [31:0] index, logic [31:0] data,
                                             bit carry);
    in_item_t item;
    item.instruction = ins;
    item.base_value  = base;
    item.index_value = index;
    item.store_value = data;
    item.carry_flag  = carry;
    return item;
  endfunction

  // Register values lean toward the corners where the adder and shifter wrap.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MaxPrintedMismatches) begin
      $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Offers one instruction item, possibly after a short gap, and holds it until taken.
  // Acceptance is judged at the falling edge, where every signal is settled, and the
  // task returns at the rising edge that took the item.
  task automatic send_transfer(in_item_t item);
    bit taken;
    taken = 1'b0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        pending_requests.push_back(predict_request(item));
      end
      @(posedge clk_i);
    end
  endtask

  // Drops valid and waits until every expected request has come out.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_requests.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_immediate_offsets();
    // Word load, pre-indexed up by the largest immediate, no writeback.
    send_transfer(make_transfer(transfer_word(1, 0, 1, 1, 0, 0, 1, 4'd1, 4'd2, 12'hFFF),
                                32'h0000_1000, $urandom, $urandom, 1'b0));
    // Word store, post-indexed down by zero.
    send_transfer(make_transfer(transfer_word(1, 0, 0, 0, 0, 0, 0, 4'd15, 4'd0, 12'h000),
                                32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1));
    // Byte store that wraps below zero, with writeback.
    send_transfer(make_transfer(transfer_word(1, 0, 1, 0, 1, 1, 0, 4'd0, 4'd15, 12'hFFF),
                                32'd0, 32'd0, 32'hA5A5_5A5A, 1'b0));
    // Post-indexing with the writeback bit set still accesses the base.
    send_transfer(make_transfer(transfer_word(1, 0, 0, 1, 1, 1, 1, 4'd7, 4'd8, 12'h123),
                                32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    // Word store that wraps above the top of the address space.
    send_transfer(make_transfer(transfer_word(1, 0, 1, 1, 0, 1, 0, 4'd9, 4'd10, 12'h001),
                                32'hFFFF_FFFF, 32'd0, 32'h1234_5678, 1'b0));
  endtask

  task automatic test_shifted_index_offsets();
    // A zero amount passes the index for LSL and means 32 for LSR and ASR.
    send_transfer(make_transfer(transfer_word(1, 1, 1, 1, 0, 0, 1, 4'd2, 4'd3,
                                shift_field(5'd0, ShiftLsl, 0)),
                                32'h1000_0000, 32'h8765_4321, 32'd0, 1'b1));
    send_transfer(make_transfer(transfer_word(1, 1, 1, 1, 0, 0, 0, 4'd2, 4'd3,
                                shift_field(5'd31, ShiftLsl, 0)),
                                32'h1000_0000, 32'hFFFF_FFFF, 32'h0BAD_F00D, 1'b0));
    send_transfer(make_transfer(transfer_word(1, 1, 1, 0, 0, 1, 1, 4'd4, 4'd5,
                                shift_field(5'd0, ShiftLsr, 0)),
                                32'h2000_0000, 32'hFFFF_FFFF, 32'd0, 1'b0));
    send_transfer(make_transfer(transfer_word(1, 1, 1, 1, 0, 0, 1, 4'd4, 4'd5,
                                shift_field(5'd31, ShiftLsr, 0)),
                                32'h2000_0000, 32'hFFFF_FFFF, 32'd0, 1'b0));
    send_transfer(make_transfer(transfer_word(1, 1, 1, 1, 0, 0, 1, 4'd6, 4'd7,
                                shift_field(5'd0, ShiftAsr, 0)),
                                32'h3000_0000, 32'h8000_0000, 32'd0, 1'b0));
    send_transfer(make_transfer(transfer_word(1, 1, 1, 1, 0, 0, 1, 4'd6, 4'd7,
                                shift_field(5'd0, ShiftAsr, 0)),
                                32'h3000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1));
    send_transfer(make_transfer(transfer_word(1, 1, 1, 0, 0, 0, 1, 4'd6, 4'd7,
                                shift_field(5'd31, ShiftAsr, 0)),
                                32'h3000_0000, 32'hC000_0001, 32'd0, 1'b0));
    // A zero rotate is a rotate with extend, with the carry at bit 31.
    send_transfer(make_transfer(transfer_word(1, 1, 1, 1, 0, 0, 1, 4'd8, 4'd9,
                                shift_field(5'd0, ShiftRor, 0)),
                                32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1));
    send_transfer(make_transfer(transfer_word(1, 1, 1, 1, 0, 0, 1, 4'd8, 4'd9,
                                shift_field(5'd0, ShiftRor, 0)),
                                32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0));
    send_transfer(make_transfer(transfer_word(1, 1, 0, 1, 0, 0, 0, 4'd8, 4'd9,
                                shift_field(5'd1, ShiftRor, 0)),
                                32'h0000_0100, 32'h0000_0003, 32'hCAFE_BABE, 1'b0));
    // Bit 4 has no effect on the register word form.
    send_transfer(make_transfer(transfer_word(1, 1, 1, 1, 0, 1, 0, 4'd11, 4'd12,
                                shift_field(5'd16, ShiftRor, 1)),
                                32'h4000_0000, 32'h1234_ABCD, 32'h5555_AAAA, 1'b1));
    send_transfer(make_transfer(transfer_word(1, 1, 1, 0, 1, 0, 1, 4'd13, 4'd14,
                                shift_field(5'd5, ShiftLsl, 1)),
                                32'h4000_0000, 32'h0000_00FF, 32'd0, 1'b0));
  endtask

  task automatic test_halfword_offsets();
    // Split immediate of 0xFF, pre-indexed with writeback; the store keeps 16 bits.
    send_transfer(make_transfer(transfer_word(0, 0, 1, 1, 1, 1, 0, 4'd1, 4'd1, 12'hFBF),
                                32'h0000_8000, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0));
    // Split immediate of zero, post-indexed load with the signed-byte type bits.
    send_transfer(make_transfer(transfer_word(0, 0, 0, 0, 1, 0, 1, 4'd2, 4'd2, 12'h0D0),
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    // Plain index register, post-indexed down with the writeback bit set.
    send_transfer(make_transfer(transfer_word(0, 0, 0, 0, 0, 1, 1, 4'd3, 4'd4, 12'h0F3),
                                32'h0000_0010, 32'hFFFF_FFFF, 32'd0, 1'b0));
    // Bit 25 in the halfword form is ignored; store of the low half.
    send_transfer(make_transfer(transfer_word(0, 1, 1, 1, 0, 0, 0, 4'd5, 4'd6, 12'h0B3),
                                32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
  endtask

  // Random instruction words cover every field, including the ignored ones. A quarter
  // of them get a zero shift amount so that the special shifts come up often. The
  // sender pauses for a full drain every hundred items.
  task automatic test_random_traffic(int unsigned count);
    logic [31:0] ins;
    for (int unsigned n = 0; n < count; n++) begin
      ins = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        ins[11:7] = 5'd0;
      end
      send_transfer(make_transfer(ins, pick_value(), pick_value(), $urandom,
                                  1'($urandom_range(0, 1))));
      if (n % 100 == 99) begin
        wait_for_drain();
      end
    end
  endtask

  // Full rate on both sides for the last stretch of the run.
  task automatic test_back_to_back(int unsigned count);
    gaps_on = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      send_transfer(make_transfer($urandom, pick_value(), pick_value(), $urandom,
                                  1'($urandom_range(0, 1))));
    end
  endtask

  // The request side stalls in random bursts while gaps are on.
  always @(posedge clk_i) begin
    if (gaps_on && stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Checks each request taken from the block against the oldest expectation, and
  // ends the run if nothing has moved on either side for too long.
  always @(negedge clk_i) begin : check_requests
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_requests.size() == 0) begin
        report_mismatch("request with nothing pending", out_item_o.mem_address, 32'd0);
      end else begin
        want = pending_requests.pop_front();
        if (out_item_o.mem_address !== want.mem_address)
          report_mismatch("mem_address", out_item_o.mem_address, want.mem_address);
        if (out_item_o.is_load !== want.is_load)
          report_mismatch("is_load", 32'(out_item_o.is_load), 32'(want.is_load));
        if (out_item_o.access_size !== want.access_size)
          report_mismatch("access_size", 32'(out_item_o.access_size),
                          32'(want.access_size));
        if (out_item_o.store_data !== want.store_data)
          report_mismatch("store_data", out_item_o.store_data, want.store_data);
        if (out_item_o.data_register !== want.data_register)
          report_mismatch("data_register", 32'(out_item_o.data_register),
                          32'(want.data_register));
        if (out_item_o.writeback_enable !== want.writeback_enable)
          report_mismatch("writeback_enable", 32'(out_item_o.writeback_enable),
                          32'(want.writeback_enable));
        if (out_item_o.base_register !== want.base_register)
          report_mismatch("base_register", 32'(out_item_o.base_register),
                          32'(want.base_register));
        if (out_item_o.writeback_value !== want.writeback_value)
          report_mismatch("writeback_value", out_item_o.writeback_value,
                          want.writeback_value);
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleCycleLimit) begin
      $display("single_transfer_address_unit_core verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_immediate_offsets();
    test_shifted_index_offsets();
    test_halfword_offsets();
    test_random_traffic(320);
    test_back_to_back(60);

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_requests.size() == 0) begin
      $display("single_transfer_address_unit_core verification clean");
    end else begin
      $display("single_transfer_address_unit_core verification failed");
    end
    $finish;
  end

endmodule

### single_transfer_address_unit_core.f
+incdir+src
src/stau_pkg.sv
src/stau_front.sv
src/stau_queue.sv
src/stau_back.sv
src/single_transfer_address_unit_core.sv
tb/sv/single_transfer_address_unit_core_tb.sv
